>>> rtl/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types and constants of the flush rate monitor.
// ----------------------------------------------------------------------------
package frm_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 64;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 48;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  // Arithmetic constants
  localparam logic [31:0] MS_PER_SEC    = 32'd1000;
  localparam logic [31:0] MIN_WINDOW_MS = 32'd100;
  localparam logic [15:0] FLUSH_MAX     = 16'hFFFF;
  localparam logic [31:0] FRAME_MAX     = 32'hFFFF_FFFF;

  // Operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MO_PIX,
    MO_CNT,
    MO_FPX,
    MO_DEN,
    MO_NLO,
    MO_NHI
  } mul_op_e;

  // Operand selection of the serial divider
  typedef enum logic [1:0] {
    DS_FLUSH,
    DS_FRAME
  } div_sel_e;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_op_e  mul_op;
    logic     write;
    logic     scan_rd;
    logic     div_start;
    div_sel_e div_sel;
    logic     den_cap;
    logic     num_cap;
    logic     num_add;
    logic     flush_cap;
    logic     frame_cap;
    logic     out_load;
  } frm_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_busy;
    logic out_busy;
  } frm_sts_t;

endpackage

>>> rtl/frm_ctrl.sv
// ----------------------------------------------------------------------------
// frm_ctrl
// Sequencer of the flush rate monitor: steps one request through store,
// scan, multiply and divide phases of the datapath.
// ----------------------------------------------------------------------------
module frm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  frm_pkg::frm_sts_t sts_i,
  output frm_pkg::frm_cmd_t cmd_o
);
  import frm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_PIX, ST_WRITE, ST_SCAN, ST_SCAN_TAIL, ST_MUL_CNT,
    ST_DIV_FL, ST_WAIT_FL, ST_MUL_FPX, ST_MUL_DEN,
    ST_MUL_NLO, ST_MUL_NHI, ST_NUM_ADD, ST_DIV_FR, ST_WAIT_FR, ST_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL_PIX;
        end
      end
      ST_MUL_PIX: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MO_PIX;
        state_d      = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) state_d = ST_SCAN_TAIL;
      end
      ST_SCAN_TAIL: state_d = ST_MUL_CNT;
      ST_MUL_CNT: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MO_CNT;
        state_d      = ST_DIV_FL;
      end
      ST_DIV_FL: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DS_FLUSH;
        state_d         = ST_WAIT_FL;
      end
      ST_WAIT_FL: begin
        if (!sts_i.div_busy) begin
          cmd_o.flush_cap = 1'b1;
          state_d         = ST_MUL_FPX;
        end
      end
      ST_MUL_FPX: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MO_FPX;
        state_d      = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MO_DEN;
        state_d      = ST_MUL_NLO;
      end
      ST_MUL_NLO: begin
        cmd_o.den_cap = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_op  = MO_NLO;
        state_d       = ST_MUL_NHI;
      end
      ST_MUL_NHI: begin
        cmd_o.num_cap = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_op  = MO_NHI;
        state_d       = ST_NUM_ADD;
      end
      ST_NUM_ADD: begin
        cmd_o.num_add = 1'b1;
        state_d       = ST_DIV_FR;
      end
      ST_DIV_FR: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DS_FRAME;
        state_d         = ST_WAIT_FR;
      end
      ST_WAIT_FR: begin
        if (!sts_i.div_busy) begin
          cmd_o.frame_cap = 1'b1;
          state_d         = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/frm_dpath.sv
// ----------------------------------------------------------------------------
// frm_dpath
// Datapath of the flush rate monitor: sample ring, scan accumulators,
// shared multiplier, serial divider and output register.
// ----------------------------------------------------------------------------
module frm_dpath #(
  parameter int unsigned HISTORY_DEPTH = frm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  frm_pkg::frm_cmd_t               cmd_i,
  output frm_pkg::frm_sts_t               sts_o,
  input  logic [frm_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic                            cfg_valid_i,
  input  logic [frm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [frm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [frm_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import frm_pkg::*;

  localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W = 32 + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

  // Configuration registers
  logic [15:0] frame_w_q, frame_h_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= '0;
      frame_h_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_w_q <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the request: time and rectangle extents
  logic [31:0] time_q, ext_w_q, ext_h_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      time_q  <= in_data_i[31:0];
      ext_w_q <= 32'(in_data_i[79:64]) - 32'(in_data_i[47:32]) + 32'd1;
      ext_h_q <= 32'(in_data_i[95:80]) - 32'(in_data_i[63:48]) + 32'd1;
    end
  end

  // Sample ring: time in the low word, pixels in the high word
  logic [63:0]              mem_q [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] valid_q;
  logic [IDX_W-1:0]         slot_q, scan_idx_q;
  logic [63:0]              rd_data_q;
  logic                     rd_vld_q, acc_en_q;
  logic [63:0]              prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) mem_q[slot_q] <= {prod_q[31:0], time_q};
    if (cmd_i.scan_rd) rd_data_q <= mem_q[scan_idx_q];
  end

  // Track written entries, the write slot and the scan address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      slot_q     <= '0;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      acc_en_q   <= 1'b0;
    end else begin
      if (cmd_i.write) begin
        valid_q[slot_q] <= 1'b1;
        slot_q          <= (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
      end
      if (cmd_i.accept) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
      rd_vld_q <= cmd_i.scan_rd & valid_q[scan_idx_q];
      acc_en_q <= cmd_i.scan_rd;
    end
  end

  assign sts_o.scan_last = (scan_idx_q == LAST_IDX);

  // Accumulate oldest, newest, count and pixel sum over occupied slots
  logic [31:0]      oldest_q, newest_q, scan_ts;
  logic [CNT_W-1:0] count_q;
  logic [SUM_W-1:0] sum_q;
  assign scan_ts = rd_vld_q ? rd_data_q[31:0] : 32'd0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      oldest_q <= '0;
      newest_q <= '0;
      count_q  <= '0;
      sum_q    <= '0;
    end else if (acc_en_q && scan_ts != 32'd0) begin
      if (oldest_q == 32'd0 || scan_ts < oldest_q) oldest_q <= scan_ts;
      if (scan_ts > newest_q) newest_q <= scan_ts;
      count_q <= count_q + 1'b1;
      sum_q   <= sum_q + SUM_W'(rd_data_q[63:32]);
    end
  end

  logic [31:0] dur;
  assign dur = newest_q - oldest_q;

  // Shared 32x32 multiplier, registered product
  logic [31:0] mul_a, mul_b;
  always_comb begin
    case (cmd_i.mul_op)
      MO_PIX: begin mul_a = ext_w_q; mul_b = ext_h_q; end
      MO_CNT: begin mul_a = 32'(count_q - 1'b1); mul_b = MS_PER_SEC; end
      MO_FPX: begin mul_a = 32'(frame_w_q); mul_b = 32'(frame_h_q); end
      MO_DEN: begin mul_a = dur; mul_b = prod_q[31:0]; end
      MO_NLO: begin mul_a = sum_q[31:0]; mul_b = MS_PER_SEC; end
      MO_NHI: begin mul_a = 32'(sum_q[SUM_W-1:32]); mul_b = MS_PER_SEC; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Frame numerator: pixel sum times 1000 plus half the divisor for rounding
  logic [63:0] den_q, num_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= 64'(mul_a) * 64'(mul_b);
    if (cmd_i.den_cap) den_q <= prod_q;
    if (cmd_i.num_cap) begin
      num_q <= prod_q;
    end else if (cmd_i.num_add) begin
      num_q <= num_q + {prod_q[31:0], 32'd0} + (den_q >> 1);
    end
  end

  // Restoring divider, one quotient bit per cycle; adding half the divisor
  // to the numerator rounds the quotient to nearest
  logic [63:0] rem_q, quo_q, dvs_q;
  logic [6:0]  div_cnt_q;
  logic [64:0] rem_sh, rem_sub;
  logic        div_ge;
  assign rem_sh  = {rem_q, quo_q[63]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign div_ge  = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= 7'd64;
    end else if (div_cnt_q != 7'd0) begin
      div_cnt_q <= div_cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      case (cmd_i.div_sel)
        DS_FLUSH: begin quo_q <= prod_q + 64'(dur >> 1); dvs_q <= 64'(dur); end
        DS_FRAME: begin quo_q <= num_q;                  dvs_q <= den_q;    end
        default:  begin quo_q <= '0;                     dvs_q <= '1;       end
      endcase
    end else if (div_cnt_q != 7'd0) begin
      rem_q <= div_ge ? rem_sub[63:0] : rem_sh[63:0];
      quo_q <= {quo_q[62:0], div_ge};
    end
  end

  assign sts_o.div_busy = (div_cnt_q != 7'd0);

  // Select results with their guard conditions and saturation
  logic [15:0] flush_q;
  logic [31:0] frame_q;
  logic        fl_ok, fr_ok;
  assign fl_ok = (count_q >= CNT_W'(2)) && (dur != 32'd0);
  assign fr_ok = (dur >= MIN_WINDOW_MS) && (sum_q != '0) &&
                 (frame_w_q != 16'd0) && (frame_h_q != 16'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.flush_cap) begin
      flush_q <= !fl_ok ? 16'd0 : (quo_q > 64'(FLUSH_MAX)) ? FLUSH_MAX : quo_q[15:0];
    end
    if (cmd_i.frame_cap) begin
      frame_q <= !fr_ok ? 32'd0 : (quo_q > 64'(FRAME_MAX)) ? FRAME_MAX : quo_q[31:0];
    end
  end

  // Output register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_data_q <= {frame_q, flush_q};
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

  // Checks
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !sts_o.div_busy) else $error("divider restarted while busy");
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_en_q |=> (count_q <= CNT_W'(HISTORY_DEPTH))) else $error("sample count overflow");

endmodule

>>> rtl/flush_rate_monitor.sv
// ----------------------------------------------------------------------------
// flush_rate_monitor
// Display flush rate monitor with a ring of timestamped pixel samples.
// ----------------------------------------------------------------------------
// Each request is one flush event; the block stores it in a ring of
// HISTORY_DEPTH samples, scans the ring at one slot per cycle, then runs
// two divisions on a single serial divider (rounding folded into the
// numerator) plus multiply steps on one shared 32x32 multiplier. The
// result is then loaded into the output register; a new request is taken
// in the cycle after that, so the block takes no new request before the
// last one is through. A held result stalls the block.
// s_axis_tdata: time_ms[31:0], left_col[47:32], top_row[63:48],
// right_col[79:64], bottom_row[95:80].
// m_axis_tdata: flush_rate[15:0], frame_rate[47:16].
module flush_rate_monitor #(
  parameter int unsigned HISTORY_DEPTH = frm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // time_ms, left_col, top_row, right_col, bottom_row (low to high)
  input  logic [frm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // flush_rate, frame_rate (low to high)
  output logic [frm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [frm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [frm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import frm_pkg::*;

  frm_cmd_t cmd;
  frm_sts_t sts;

  assign cfg_ready_o = 1'b1;

  frm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  frm_dpath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> bench/tb_flush_rate_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flush_rate_monitor
// Self-checking bench for the flush rate monitor.
// ----------------------------------------------------------------------------
// Flush events go in through the input stream. A local copy of the sample
// ring predicts the flush rate and the frame rate of each event, and every
// result is compared with the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_flush_rate_monitor;
  import frm_pkg::*;

  localparam int unsigned DEPTH     = HISTORY_DEPTH_DEF;
  localparam int unsigned IDLE_MAX  = 20000;
  localparam int unsigned DRAIN_CYC = DEPTH + 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

  typedef struct packed {
    logic [15:0] bottom_row;
    logic [15:0] right_col;
    logic [15:0] top_row;
    logic [15:0] left_col;
    logic [31:0] time_ms;
  } flush_event_t;

  typedef struct packed {
    logic [31:0] frame_rate;
    logic [15:0] flush_rate;
  } rate_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  flush_rate_monitor DUT (.*);

  always #4 clk_i = ~clk_i;

  // Predictor state
  logic [31:0] ring_time [DEPTH];
  logic [31:0] ring_pix [DEPTH];
  int unsigned next_slot;
  logic [15:0] panel_w, panel_h;

  flush_event_t event_queue[$];
  rate_result_t rate_queue[$];
  int unsigned errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_cycles = 0;
  int unsigned idle_cycles = 0;

  // Compute the expected rates after storing one flush event
  function automatic rate_result_t predict_rates(flush_event_t ev);
    logic [31:0] oldest, newest, count, span, wid, hgt;
    logic [63:0] pix_sum, r, fr, fpx, div;
    rate_result_t res;
    oldest = 0; newest = 0; count = 0; pix_sum = 0;
    wid = {16'd0, ev.right_col} - {16'd0, ev.left_col} + 32'd1;
    hgt = {16'd0, ev.bottom_row} - {16'd0, ev.top_row} + 32'd1;
    ring_time[next_slot] = ev.time_ms;
    ring_pix[next_slot] = wid * hgt;
    next_slot = (next_slot + 1) % DEPTH;
    for (int i = 0; i < DEPTH; i++) begin
      if (ring_time[i] != 0) begin
        if (oldest == 0 || ring_time[i] < oldest) oldest = ring_time[i];
        if (ring_time[i] > newest) newest = ring_time[i];
        count++;
        pix_sum += ring_pix[i];
      end
    end
    span = newest - oldest;
    res = '0;
    if (count >= 2 && span != 0) begin
      r = (64'(count - 1) * 64'd1000000) / 64'(span);
      fr = (r + 64'd500) / 64'd1000;
      res.flush_rate = (fr > 64'hFFFF) ? 16'hFFFF : fr[15:0];
    end
    fpx = 64'(panel_w) * 64'(panel_h);
    if (span >= 32'd100 && pix_sum != 0 && fpx != 0) begin
      div = 64'(span) * fpx;
      r = (pix_sum * 64'd1000000) / div;
      fr = (r + 64'd500) / 64'd1000;
      res.frame_rate = (fr > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fr[31:0];
    end
    return res;
  endfunction

  // Sender: offer queued events with random gaps
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      rate_queue.push_back(predict_rates(flush_event_t'(s_axis_tdata)));
      void'(event_queue.pop_front());
    end
    if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      s_axis_tvalid <= 1'b1;
    end else if (event_queue.size() > 0 && $urandom_range(0, 9) < 7) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= event_queue[0];
    end else begin
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(0, 19) == 0) gap_left <= $urandom_range(20, 600);
    end
  end

  // Receiver: check results, stall at random
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (rate_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        if (rate_queue[0].flush_rate !== m_axis_tdata[15:0]) begin
          $display("%0t: flush_rate expected %0d actual %0d", $time,
                   rate_queue[0].flush_rate, m_axis_tdata[15:0]);
          errors++;
        end
        if (rate_queue[0].frame_rate !== m_axis_tdata[47:16]) begin
          $display("%0t: frame_rate expected %0d actual %0d", $time,
                   rate_queue[0].frame_rate, m_axis_tdata[47:16]);
          errors++;
        end
        void'(rate_queue.pop_front());
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 29) == 0) stall_left <= $urandom_range(10, 900);
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("[flush_rate_monitor] ERROR");
      $finish;
    end
  end

  // Write one register, then leave the channel idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_FRAME_WIDTH) panel_w = val;
    else if (idx == REG_FRAME_HEIGHT) panel_h = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every queued event has been answered
  task automatic drain();
    while (event_queue.size() != 0 || rate_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic push_event(input logic [31:0] t, input logic [15:0] x1, y1, x2, y2);
    flush_event_t ev;
    ev.time_ms = t; ev.left_col = x1; ev.top_row = y1;
    ev.right_col = x2; ev.bottom_row = y2;
    event_queue.push_back(ev);
  endtask

  // Mostly monotonic time with small rectangles; some raw noise
  task automatic push_random(inout logic [31:0] clock_ms);
    logic [15:0] x1, y1;
    case ($urandom_range(0, 9))
      0: push_event($urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
      1: push_event(0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      default: begin
        clock_ms += $urandom_range(0, 80);
        x1 = 16'($urandom_range(0, 800));
        y1 = 16'($urandom_range(0, 600));
        push_event(clock_ms, x1, y1, x1 + 16'($urandom_range(0, 400)),
                   y1 + 16'($urandom_range(0, 300)));
      end
    endcase
  endtask

  logic [31:0] clock_ms;
  logic [15:0] sizes [4] = '{16'd0, 16'hFFFF, 16'd240, 16'd1};

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      ring_time[i] = 0;
      ring_pix[i] = 0;
    end
    next_slot = 0;
    panel_w = 0;
    panel_h = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero frame size first, then edge rectangles and times
    push_event(1000, 0, 0, 0, 0);
    push_event(1000, 0, 0, 65535, 65535);
    push_event(0, 10, 10, 20, 20);
    push_event(1050, 0, 0, 9, 9);
    drain();
    cfg_write(REG_FRAME_WIDTH, 16'd320);
    cfg_write(REG_FRAME_HEIGHT, 16'd240);
    cfg_write(REG_UNUSED, 16'hFFFF);
    push_event(1150, 0, 0, 319, 239);
    push_event(1151, 100, 100, 50, 50);
    push_event(32'hFFFF_FFFF, 65535, 65535, 0, 0);
    push_event(1, 0, 0, 65535, 65535);
    push_event(2, 5, 5, 5, 5);
    push_event(3, 65535, 0, 65535, 0);
    drain();
    cfg_write(REG_FRAME_WIDTH, 16'd1);
    cfg_write(REG_FRAME_HEIGHT, 16'd1);
    // Many samples in a 110 ms window with huge rectangles: saturation
    for (int i = 0; i < 12; i++) push_event(5000 + i * 10, 0, 0, 65535, 65535);
    drain();

    // Long receiver hold-off while the sender keeps offering
    hold_cycles = 3000;
    for (int i = 0; i < 10; i++) push_event(6000 + i * 33, 0, 0, 99, 99);
    drain();

    clock_ms = 32'd100000;
    for (int phase = 0; phase < 4; phase++) begin
      cfg_write(REG_FRAME_WIDTH, sizes[phase]);
      cfg_write(REG_FRAME_HEIGHT, sizes[(phase + 1) % 4] ^ 16'(phase));
      for (int i = 0; i < 205; i++) push_random(clock_ms);
      drain();
    end

    if (errors == 0 && rate_queue.size() == 0) begin
      $display("[flush_rate_monitor] OK");
    end else begin
      $display("[flush_rate_monitor] ERROR");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/frm_pkg.sv
rtl/frm_ctrl.sv
rtl/frm_dpath.sv
rtl/flush_rate_monitor.sv
bench/tb_flush_rate_monitor.sv
